[rtl/core/timing_hit_chi2_outlier_filter_defines.svh]
// Assertion helpers shared by the timing-hit filter RTL.
`ifndef TIMING_HIT_CHI2_OUTLIER_FILTER_DEFINES_SVH
`define TIMING_HIT_CHI2_OUTLIER_FILTER_DEFINES_SVH

// Condition must never hold outside reset.
`define THCOF_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define THCOF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define THCOF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/thcof_pkg.sv]
package thcof_pkg;

   localparam int HITS       = 4;
   localparam int PAIRS      = 6;
   localparam int TIME_W     = 19;
   localparam int DIFF_W     = TIME_W + 1;
   localparam int SQ_W       = 2 * TIME_W;
   localparam int D_W        = SQ_W + 3;
   localparam int CMP_W      = D_W + 8;
   localparam int LIMIT_W    = 16;
   localparam int CUT_W      = 12;
   localparam int RES_W      = 10;
   localparam int RES2_W     = 2 * RES_W;
   localparam int R_W        = CUT_W + RES_W;
   localparam int LR2_W      = LIMIT_W + RES2_W;
   localparam int R2_W       = 2 * R_W;
   localparam int THR_W      = LR2_W + 2;
   localparam int THR2_W     = R2_W + 1;
   localparam int CMP2_W     = SQ_W + 16;
   localparam int PIDX_W     = 3;
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = 3;
   localparam int CNT_W      = 4;

   localparam logic [LIMIT_W-1:0] CHI2_LIMIT_RESET = 16'd1024;
   localparam logic [CUT_W-1:0]   DELTA_T_CUT_RESET = 12'd512;
   localparam logic [RES_W-1:0]   HIT_RESOLUTION_RESET = 10'd35;

   typedef enum logic [1:0] {
      CSR_CHI2_LIMIT     = 2'd0,
      CSR_DELTA_T_CUT    = 2'd1,
      CSR_HIT_RESOLUTION = 2'd2
   } csr_index_type;

   // Layer pairs handled by the lanes: (0,1) (0,2) (0,3) (1,2) (1,3) (2,3).
   localparam logic [1:0] PAIR_A [PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] PAIR_B [PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   typedef struct packed {
      logic       valid;
      logic [3:0] mask;
      logic [3:0] prime;
   } item_ctl_type;

   typedef struct packed {
      logic [3:0] mask;
      logic [2:0] count;
      logic [3:0] prime;
   } rsp_entry_type;

   // Lane index of the pair formed by the two set bits of a mask.
   function automatic logic [PIDX_W-1:0] pair_sel(input logic [3:0] m);
      logic [PIDX_W-1:0] p;
      case (m)
         4'b0011: p = 3'd0;
         4'b0101: p = 3'd1;
         4'b1001: p = 3'd2;
         4'b0110: p = 3'd3;
         4'b1010: p = 3'd4;
         4'b1100: p = 3'd5;
         default: p = 3'd0;
      endcase
      return p;
   endfunction

endpackage

[rtl/core/thcof_pair_lane.sv]
module thcof_pair_lane (
   input  logic                                 clock,
   input  logic signed [thcof_pkg::TIME_W-1:0]  time_a,
   input  logic signed [thcof_pkg::TIME_W-1:0]  time_b,
   output logic        [thcof_pkg::SQ_W-1:0]    sq_ff
);

   logic signed [thcof_pkg::DIFF_W-1:0]   diff;
   logic signed [2*thcof_pkg::DIFF_W-1:0] prod;
   logic        [thcof_pkg::SQ_W-1:0]     sq_in;

   // Square of the time difference; never exceeds SQ_W bits.
   always_comb begin
      diff  = thcof_pkg::DIFF_W'(time_a) - thcof_pkg::DIFF_W'(time_b);
      prod  = diff * diff;
      sq_in = prod[thcof_pkg::SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

endmodule

[rtl/core/thcof_select.sv]
module thcof_select (
   input  logic                              clock,
   input  logic                              reset,
   input  thcof_pkg::item_ctl_type           ctl,
   input  logic [thcof_pkg::SQ_W-1:0]        sq [thcof_pkg::PAIRS],
   input  logic [thcof_pkg::LR2_W-1:0]       lim_res2,
   input  logic [thcof_pkg::R2_W-1:0]        r2,
   output thcof_pkg::item_ctl_type           res_ff
);

   // Stage one: subset spreads and thresholds.
   thcof_pkg::item_ctl_type           t1_ctl_ff, t1_ctl_in;
   logic [thcof_pkg::SQ_W-1:0]        t1_sq_ff [thcof_pkg::PAIRS];
   logic [thcof_pkg::D_W-1:0]         t1_d3_ff [thcof_pkg::HITS];
   logic [thcof_pkg::D_W-1:0]         t1_d3_in [thcof_pkg::HITS];
   logic [thcof_pkg::D_W-1:0]         t1_d4_ff, t1_d4_in;
   logic [thcof_pkg::THR_W-1:0]       t1_thr3_ff, t1_thr3_in, t1_thr4_ff, t1_thr4_in;
   logic [thcof_pkg::THR2_W-1:0]      t1_thr2_ff, t1_thr2_in;

   // Stage two: full-set test and first removal.
   thcof_pkg::item_ctl_type           t2_ctl_ff;
   logic [2:0]                        t2_n_ff, t2_n_in;
   logic                              t2_ok4_ff, t2_ok4_in;
   logic [3:0]                        t2_m3_ff, t2_m3_in;
   logic [thcof_pkg::D_W-1:0]         t2_d3_ff, t2_d3_in;
   logic [thcof_pkg::SQ_W-1:0]        t2_sq_ff [thcof_pkg::PAIRS];
   logic [thcof_pkg::THR_W-1:0]       t2_thr3_ff;
   logic [thcof_pkg::THR2_W-1:0]      t2_thr2_ff;
   logic [1:0]                        best4, rm;
   logic [thcof_pkg::D_W-1:0]         best4_d;

   // Stage three: three-hit test and second removal.
   thcof_pkg::item_ctl_type           t3_ctl_ff;
   logic [3:0]                        t3_final_ff, t3_final_in;
   logic                              t3_need_dt_ff, t3_need_dt_in;
   logic [3:0]                        t3_m2_ff, t3_m2_in;
   logic [thcof_pkg::SQ_W-1:0]        t3_sq2_ff, t3_sq2_in;
   logic [thcof_pkg::THR2_W-1:0]      t3_thr2_ff;
   logic                              ok3, found;
   logic [3:0]                        best_m2, cand;
   logic [thcof_pkg::SQ_W-1:0]        best_sq;

   // Stage four: two-hit test.
   thcof_pkg::item_ctl_type           res_in;
   logic                              dok;

   always_comb begin
      t1_ctl_in = ctl;
      t1_d4_in  = '0;
      for (int i = 0; i < thcof_pkg::HITS; i++) begin
         t1_d3_in[i] = '0;
      end
      for (int p = 0; p < thcof_pkg::PAIRS; p++) begin
         t1_d4_in = t1_d4_in + thcof_pkg::D_W'(sq[p]);
         for (int i = 0; i < thcof_pkg::HITS; i++) begin
            if (thcof_pkg::PAIR_A[p] != 2'(i) && thcof_pkg::PAIR_B[p] != 2'(i)) begin
               t1_d3_in[i] = t1_d3_in[i] + thcof_pkg::D_W'(sq[p]);
            end
         end
      end
      t1_thr3_in = thcof_pkg::THR_W'({lim_res2, 1'b0}) + thcof_pkg::THR_W'(lim_res2);
      t1_thr4_in = {lim_res2, 2'b00};
      t1_thr2_in = {r2, 1'b0};
   end

   always_comb begin
      t2_n_in   = 3'($countones(t1_ctl_ff.mask));
      t2_ok4_in = {t1_d4_ff, 8'b0} < thcof_pkg::CMP_W'(t1_thr4_ff);
      best4     = 2'd0;
      best4_d   = t1_d3_ff[0];
      for (int i = 1; i < thcof_pkg::HITS; i++) begin
         if (t1_d3_ff[i] < best4_d) begin
            best4   = 2'(i);
            best4_d = t1_d3_ff[i];
         end
      end
      // With three hits the dropped layer is the absent one.
      rm = best4;
      if (t2_n_in != 3'd4) begin
         for (int i = 0; i < thcof_pkg::HITS; i++) begin
            if (!t1_ctl_ff.mask[i]) begin
               rm = 2'(i);
            end
         end
      end
      t2_m3_in = t1_ctl_ff.mask & ~(4'b0001 << rm);
      t2_d3_in = t1_d3_ff[rm];
   end

   always_comb begin
      ok3     = {t2_d3_ff, 8'b0} < thcof_pkg::CMP_W'(t2_thr3_ff);
      found   = 1'b0;
      best_m2 = 4'b0;
      best_sq = '0;
      cand    = 4'b0;
      for (int i = 0; i < thcof_pkg::HITS; i++) begin
         if (t2_m3_ff[i]) begin
            cand = t2_m3_ff & ~(4'b0001 << i);
            if (!found || t2_sq_ff[thcof_pkg::pair_sel(cand)] < best_sq) begin
               found   = 1'b1;
               best_m2 = cand;
               best_sq = t2_sq_ff[thcof_pkg::pair_sel(cand)];
            end
         end
      end
      t3_final_in   = t2_ctl_ff.mask;
      t3_need_dt_in = 1'b0;
      t3_m2_in      = best_m2;
      if (t2_n_ff <= 3'd1) begin
         t3_final_in = t2_ctl_ff.mask;
      end else if (t2_n_ff == 3'd2) begin
         t3_need_dt_in = 1'b1;
         t3_m2_in      = t2_ctl_ff.mask;
      end else if (t2_n_ff == 3'd4 && t2_ok4_ff) begin
         t3_final_in = t2_ctl_ff.mask;
      end else if (ok3) begin
         t3_final_in = t2_m3_ff;
      end else begin
         t3_need_dt_in = 1'b1;
      end
      t3_sq2_in = t2_sq_ff[thcof_pkg::pair_sel(t3_m2_in)];
   end

   always_comb begin
      dok          = {t3_sq2_ff, 16'b0} < thcof_pkg::CMP2_W'(t3_thr2_ff);
      res_in.valid = t3_ctl_ff.valid;
      res_in.mask  = t3_need_dt_ff ? (dok ? t3_m2_ff : 4'b0) : t3_final_ff;
      res_in.prime = res_in.mask & t3_ctl_ff.prime;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ctl_ff.valid <= 1'b0;
         t2_ctl_ff.valid <= 1'b0;
         t3_ctl_ff.valid <= 1'b0;
         res_ff.valid    <= 1'b0;
      end else begin
         t1_ctl_ff.valid <= t1_ctl_in.valid;
         t2_ctl_ff.valid <= t1_ctl_ff.valid;
         t3_ctl_ff.valid <= t2_ctl_ff.valid;
         res_ff.valid    <= res_in.valid;
      end

      t1_ctl_ff.mask  <= t1_ctl_in.mask;
      t1_ctl_ff.prime <= t1_ctl_in.prime;
      t1_sq_ff        <= sq;
      t1_d3_ff        <= t1_d3_in;
      t1_d4_ff        <= t1_d4_in;
      t1_thr3_ff      <= t1_thr3_in;
      t1_thr4_ff      <= t1_thr4_in;
      t1_thr2_ff      <= t1_thr2_in;

      t2_ctl_ff.mask  <= t1_ctl_ff.mask;
      t2_ctl_ff.prime <= t1_ctl_ff.prime;
      t2_n_ff         <= t2_n_in;
      t2_ok4_ff       <= t2_ok4_in;
      t2_m3_ff        <= t2_m3_in;
      t2_d3_ff        <= t2_d3_in;
      t2_sq_ff        <= t1_sq_ff;
      t2_thr3_ff      <= t1_thr3_ff;
      t2_thr2_ff      <= t1_thr2_ff;

      t3_ctl_ff.mask  <= t2_ctl_ff.mask;
      t3_ctl_ff.prime <= t2_ctl_ff.prime;
      t3_final_ff     <= t3_final_in;
      t3_need_dt_ff   <= t3_need_dt_in;
      t3_m2_ff        <= t3_m2_in;
      t3_sq2_ff       <= t3_sq2_in;
      t3_thr2_ff      <= t2_thr2_ff;

      res_ff.mask     <= res_in.mask;
      res_ff.prime    <= res_in.prime;
   end

endmodule

[rtl/core/timing_hit_chi2_outlier_filter.sv]
// Channel    | Ports                                   | Transfer when
// -----------+-----------------------------------------+---------------------------
// request    | req_valid/req_stall, mask, prime, times | req_valid && !req_stall
// response   | rsp_valid/rsp_stall, accepted fields    | rsp_valid && !rsp_stall
// csr write  | csr_valid/csr_ready, index, wdata       | csr_valid && csr_ready
//
// One track enters per cycle while req_stall is low; its result passes the input,
// lane, merge and queue registers in that order before it is offered.
// Six pair lanes square the time differences in parallel; the merge pipeline
// (four stages) picks the surviving hits with adds and compares only.
// An eight-entry result queue absorbs response stalls; request stalls only once
// eight tracks are in flight or queued. Synchronous reset clears control and
// restores the register defaults; no clearing pass.
`include "timing_hit_chi2_outlier_filter_defines.svh"

module timing_hit_chi2_outlier_filter #(
   parameter int NUM_LAYERS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [3:0]                         req_hit_valid_mask,
   input  logic [3:0]                         req_prime_mask,
   input  logic signed [thcof_pkg::TIME_W-1:0] req_time_0,
   input  logic signed [thcof_pkg::TIME_W-1:0] req_time_1,
   input  logic signed [thcof_pkg::TIME_W-1:0] req_time_2,
   input  logic signed [thcof_pkg::TIME_W-1:0] req_time_3,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_accepted_mask,
   output logic [2:0]                         rsp_accepted_count,
   output logic [3:0]                         rsp_accepted_prime_mask,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [15:0]                        csr_wdata
);

   // Only four time fields exist, so layers above four are never used.
   localparam int LANES = (NUM_LAYERS < thcof_pkg::HITS) ? NUM_LAYERS : thcof_pkg::HITS;
   localparam logic [3:0] LAYER_MASK = 4'((1 << LANES) - 1);
   localparam logic [thcof_pkg::CNT_W-1:0] FIFO_FULL = thcof_pkg::CNT_W'(thcof_pkg::FIFO_DEPTH);
   localparam logic [thcof_pkg::CNT_W-1:0] ONE_TRACK = thcof_pkg::CNT_W'(1);

   // Configuration registers.
   logic [thcof_pkg::LIMIT_W-1:0] chi2_limit_ff;
   logic [thcof_pkg::CUT_W-1:0]   delta_t_cut_ff;
   logic [thcof_pkg::RES_W-1:0]   hit_resolution_ff;

   // Input stage.
   logic                                in_fire, out_fire;
   thcof_pkg::item_ctl_type             s1_ctl_ff, s1_ctl_in;
   logic signed [thcof_pkg::TIME_W-1:0] time_ff [thcof_pkg::HITS];
   logic [thcof_pkg::RES2_W-1:0]        res2_ff;
   logic [thcof_pkg::R_W-1:0]           r_ff;

   // Lane stage.
   thcof_pkg::item_ctl_type             s2_ctl_ff;
   logic [thcof_pkg::SQ_W-1:0]          sq [thcof_pkg::PAIRS];
   logic [thcof_pkg::LR2_W-1:0]         lim_res2_ff;
   logic [thcof_pkg::R2_W-1:0]          r2_ff;

   // Merge result and queue.
   thcof_pkg::item_ctl_type             sel_res;
   thcof_pkg::rsp_entry_type            fifo_mem_ff [thcof_pkg::FIFO_DEPTH];
   thcof_pkg::rsp_entry_type            push_entry, head;
   logic [thcof_pkg::PTR_W-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [thcof_pkg::CNT_W-1:0]         occ_ff, occ_in, inflight_ff, inflight_in;

   // Assertion helpers.
   logic                                queue_overflow, head_count_ok, track_added;
   logic [thcof_pkg::CNT_W-1:0]         inflight_up;

   assign csr_ready = 1'b1;

   // Hold the register set; writes outside the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         chi2_limit_ff     <= thcof_pkg::CHI2_LIMIT_RESET;
         delta_t_cut_ff    <= thcof_pkg::DELTA_T_CUT_RESET;
         hit_resolution_ff <= thcof_pkg::HIT_RESOLUTION_RESET;
      end else if (csr_valid && csr_ready) begin
         case (thcof_pkg::csr_index_type'(csr_index))
            thcof_pkg::CSR_CHI2_LIMIT:
               chi2_limit_ff <= csr_wdata[thcof_pkg::LIMIT_W-1:0];
            thcof_pkg::CSR_DELTA_T_CUT:
               delta_t_cut_ff <= csr_wdata[thcof_pkg::CUT_W-1:0];
            thcof_pkg::CSR_HIT_RESOLUTION:
               hit_resolution_ff <= csr_wdata[thcof_pkg::RES_W-1:0];
            default: ;
         endcase
      end
   end

   // Stall only when every queue slot is spoken for by a track in flight.
   assign req_stall = (inflight_ff == FIFO_FULL);
   assign in_fire   = req_valid && !req_stall;
   assign out_fire  = rsp_valid && !rsp_stall;

   always_comb begin
      s1_ctl_in.valid = in_fire;
      s1_ctl_in.mask  = req_hit_valid_mask & LAYER_MASK;
      s1_ctl_in.prime = req_prime_mask;
   end

   // Capture the track and start the threshold products alongside it.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_ctl_ff.valid <= 1'b0;
      end else begin
         s1_ctl_ff.valid <= s1_ctl_in.valid;
         s2_ctl_ff.valid <= s1_ctl_ff.valid;
      end
      s1_ctl_ff.mask  <= s1_ctl_in.mask;
      s1_ctl_ff.prime <= s1_ctl_in.prime;
      time_ff[0]      <= req_time_0;
      time_ff[1]      <= req_time_1;
      time_ff[2]      <= req_time_2;
      time_ff[3]      <= req_time_3;
      res2_ff         <= hit_resolution_ff * hit_resolution_ff;
      r_ff            <= delta_t_cut_ff * hit_resolution_ff;
      s2_ctl_ff.mask  <= s1_ctl_ff.mask;
      s2_ctl_ff.prime <= s1_ctl_ff.prime;
      lim_res2_ff     <= chi2_limit_ff * res2_ff;
      r2_ff           <= r_ff * r_ff;
   end

   // One lane per hit pair: squared time difference.
   for (genvar p = 0; p < thcof_pkg::PAIRS; p++) begin : g_lane
      thcof_pair_lane u_lane (
         .clock  (clock),
         .time_a (time_ff[thcof_pkg::PAIR_A[p]]),
         .time_b (time_ff[thcof_pkg::PAIR_B[p]]),
         .sq_ff  (sq[p])
      );
   end

   // Merge: chi-square tests, removals and the two-hit cut.
   thcof_select u_select (
      .clock    (clock),
      .reset    (reset),
      .ctl      (s2_ctl_ff),
      .sq       (sq),
      .lim_res2 (lim_res2_ff),
      .r2       (r2_ff),
      .res_ff   (sel_res)
   );

   always_comb begin
      push_entry.mask  = sel_res.mask;
      push_entry.count = 3'($countones(sel_res.mask));
      push_entry.prime = sel_res.prime;
      head             = fifo_mem_ff[rd_ptr_ff];
      occ_in           = occ_ff + thcof_pkg::CNT_W'(sel_res.valid)
                         - thcof_pkg::CNT_W'(out_fire);
      inflight_in      = inflight_ff + thcof_pkg::CNT_W'(in_fire)
                         - thcof_pkg::CNT_W'(out_fire);
   end

   // Queue results; advance pointers on each transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         occ_ff      <= '0;
         inflight_ff <= '0;
      end else begin
         if (sel_res.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (out_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         occ_ff      <= occ_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel_res.valid) begin
         fifo_mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign rsp_valid               = (occ_ff != '0);
   assign rsp_accepted_mask       = head.mask;
   assign rsp_accepted_count      = head.count;
   assign rsp_accepted_prime_mask = head.prime;

   assign queue_overflow = sel_res.valid && !out_fire && (occ_ff == FIFO_FULL);
   assign head_count_ok  = (rsp_accepted_count == 3'($countones(rsp_accepted_mask)));
   assign track_added    = in_fire && !out_fire;
   assign inflight_up    = inflight_ff + ONE_TRACK;

   `THCOF_ASSERT_NEVER(a_occ_within_inflight, occ_ff > inflight_ff, "untracked result")
   `THCOF_ASSERT_NEVER(a_no_overflow, queue_overflow, "result queue overflow")
   `THCOF_ASSERT_IMPLY(a_count_matches, rsp_valid, head_count_ok, "count disagrees with mask")
   `THCOF_ASSERT_NEXT(a_inflight_grows, track_added, inflight_ff == $past(inflight_up), "stuck")

endmodule
